FILE: hdl/ulsf_pkg.sv
// ----------------------------------------------------------------------------
// ulsf_pkg
// Shared types and constants for the ultrasonic level sensor filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ulsf_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_LENGTH       = 3'd0,
    REG_SECOND_STAGE_ENABLE = 3'd1,
    REG_MIN_INTERVAL_TOTAL  = 3'd2,
    REG_MAX_INTERVAL_TOTAL  = 3'd3,
    REG_FLUID_SUM_TRIGGER   = 3'd4,
    REG_MAX_WAIT_CYCLES     = 3'd5,
    REG_ERROR_ALLOWANCE     = 3'd6
  } cfg_reg_t;

  // Operation codes of an input beat
  localparam logic OP_PRIME  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Wait counter saturation value
  localparam logic [8:0] WAIT_MAX = 9'd511;

  // Live configuration
  typedef struct packed {
    logic [7:0]  filter_length;
    logic        second_stage_enable;
    logic [8:0]  min_interval_total;
    logic [8:0]  max_interval_total;
    logic [10:0] fluid_sum_trigger;
    logic [7:0]  max_wait_cycles;
    logic [3:0]  error_allowance;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    filter_length:       8'd20,
    second_stage_enable: 1'b1,
    min_interval_total:  9'd175,
    max_interval_total:  9'd214,
    fluid_sum_trigger:   11'd1330,
    max_wait_cycles:     8'd20,
    error_allowance:     4'd1
  };

  // Per-beat data handed from the level filter to the statistics unit
  typedef struct packed {
    logic               prime;
    logic               clear;
    logic [8:0]         total;
    logic signed [15:0] agc;
  } stats_in_t;

  // Updated statistics, as reported with the result beat
  typedef struct packed {
    logic [8:0]         low_total;
    logic [8:0]         high_total;
    logic signed [15:0] low_agc;
    logic signed [15:0] high_agc;
    logic [22:0]        window_sum;
    logic [13:0]        window_count;
  } stats_out_t;

endpackage

`default_nettype wire

FILE: hdl/ulsf_cfg_regs.sv
// ----------------------------------------------------------------------------
// ulsf_cfg_regs
// Configuration register file with a plain indexed write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ulsf_cfg_regs
  import ulsf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_FILTER_LENGTH:       cfg.filter_length       <= cfg_data[7:0];
        REG_SECOND_STAGE_ENABLE: cfg.second_stage_enable <= cfg_data[0];
        REG_MIN_INTERVAL_TOTAL:  cfg.min_interval_total  <= cfg_data[8:0];
        REG_MAX_INTERVAL_TOTAL:  cfg.max_interval_total  <= cfg_data[8:0];
        REG_FLUID_SUM_TRIGGER:   cfg.fluid_sum_trigger   <= cfg_data[10:0];
        REG_MAX_WAIT_CYCLES:     cfg.max_wait_cycles     <= cfg_data[7:0];
        REG_ERROR_ALLOWANCE:     cfg.error_allowance     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ulsf_level_filter.sv
// ----------------------------------------------------------------------------
// ulsf_level_filter
// Counter deltas, validity window, vote count, second stage and error
// tracking. Presents the updated values for the beat being processed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ulsf_level_filter
  import ulsf_pkg::*;
#(
  parameter int HISTORY_DEPTH = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        fire,
  input  wire logic        operation,
  input  wire logic [15:0] raw_counter,
  output logic             level_next,
  output logic             fatal_next,
  output logic [7:0]       air_delta,
  output logic [7:0]       fluid_delta,
  output logic [8:0]       interval_total,
  output logic [31:0]      running_total_next
);

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W = 8 + $clog2(HISTORY_DEPTH + 1);
  localparam int CMP_W = (SUM_W > 11) ? SUM_W : 11;

  // State
  logic [7:0]       previous_air;
  logic [7:0]       previous_fluid;
  logic [7:0]       vote_count;
  logic             level;
  logic [8:0]       wait_cycles;
  logic [3:0]       errors_left;
  logic             fatal_flag;
  logic [31:0]      running_total;
  logic [7:0]       fluid_history [HISTORY_DEPTH];
  logic [PTR_W-1:0] history_pointer;

  logic             is_prime;
  logic [7:0]       ad;
  logic [7:0]       fd;
  logic [8:0]       tot;
  logic             in_window;
  logic [SUM_W-1:0] fluid_sum;
  logic [7:0]       vote_next;
  logic             first_stage;
  logic [8:0]       wait_inc;
  logic [8:0]       wait_next;
  logic [3:0]       errors_next;
  logic [PTR_W-1:0] ptr_next;

  assign is_prime = (operation == OP_PRIME);

  // Modulo-256 deltas and their total
  assign ad        = raw_counter[7:0] - previous_air;
  assign fd        = raw_counter[15:8] - previous_fluid;
  assign tot       = {1'b0, ad} + {1'b0, fd};
  assign in_window = (tot >= cfg.min_interval_total) && (tot <= cfg.max_interval_total);

  // Current fluid delta plus the stored history
  always_comb begin
    fluid_sum = SUM_W'(fd);
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      fluid_sum = fluid_sum + SUM_W'(fluid_history[i]);
    end
  end

  // Saturating vote; a down step from above the limit just decrements
  always_comb begin
    vote_next = vote_count;
    if (fd > ad) begin
      vote_next = (vote_count < cfg.filter_length) ? vote_count + 8'd1 : cfg.filter_length;
    end else if (vote_count != 8'd0) begin
      vote_next = vote_count - 8'd1;
    end
  end

  assign first_stage = vote_next > {1'b0, cfg.filter_length[7:1]};
  assign wait_inc    = (wait_cycles == WAIT_MAX) ? wait_cycles : wait_cycles + 9'd1;

  // Level and wait counter for a sample beat
  always_comb begin
    level_next = level;
    wait_next  = wait_cycles;
    if (is_prime) begin
      level_next = 1'b0;
      wait_next  = '0;
    end else if (in_window) begin
      if (!cfg.second_stage_enable) begin
        level_next = first_stage;
      end else if (first_stage) begin
        if (!level) begin
          wait_next = wait_inc;
          if ((CMP_W'(fluid_sum) > CMP_W'(cfg.fluid_sum_trigger)) ||
              (wait_inc > {1'b0, cfg.max_wait_cycles})) begin
            level_next = 1'b1;
          end
        end
      end else begin
        wait_next  = '0;
        level_next = 1'b0;
      end
    end
  end

  // Error allowance and sticky fatal flag
  always_comb begin
    errors_next = errors_left;
    fatal_next  = fatal_flag;
    if (is_prime) begin
      errors_next = cfg.error_allowance;
      fatal_next  = 1'b0;
    end else if (in_window) begin
      errors_next = cfg.error_allowance;
    end else if (errors_left == 4'd0) begin
      fatal_next = 1'b1;
    end else begin
      errors_next = errors_left - 4'd1;
    end
  end

  assign ptr_next = (history_pointer == PTR_W'(HISTORY_DEPTH - 1)) ? '0
                                                                   : history_pointer + 1'b1;

  assign running_total_next = is_prime ? 32'd0 : running_total + 32'(tot);
  assign air_delta          = is_prime ? 8'd0 : ad;
  assign fluid_delta        = is_prime ? 8'd0 : fd;
  assign interval_total     = is_prime ? 9'd0 : tot;

  // State update per processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_air    <= '0;
      previous_fluid  <= '0;
      vote_count      <= '0;
      level           <= 1'b0;
      wait_cycles     <= '0;
      errors_left     <= CFG_RESET.error_allowance;
      fatal_flag      <= 1'b0;
      running_total   <= '0;
      history_pointer <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        fluid_history[i] <= '0;
      end
    end else if (fire) begin
      previous_air   <= raw_counter[7:0];
      previous_fluid <= raw_counter[15:8];
      level          <= level_next;
      wait_cycles    <= wait_next;
      errors_left    <= errors_next;
      fatal_flag     <= fatal_next;
      running_total  <= running_total_next;
      if (is_prime) begin
        vote_count      <= '0;
        history_pointer <= '0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          fluid_history[i] <= '0;
        end
      end else begin
        if (in_window) begin
          vote_count <= vote_next;
        end
        fluid_history[history_pointer] <= fd;
        history_pointer                <= ptr_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ulsf_stats.sv
// ----------------------------------------------------------------------------
// ulsf_stats
// Windowed min/max/sum statistics of interval totals and AGC samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ulsf_stats
  import ulsf_pkg::*;
#(
  parameter int STATS_RESTART = 10000
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      fire,
  input  wire stats_in_t sin,
  output stats_out_t     sout
);

  stats_out_t st;
  logic       restart;

  // Window restarts on request, when empty, or when past its length
  assign restart = sin.clear || (st.window_count == 14'd0) ||
                   (st.window_count > 14'(STATS_RESTART));

  always_comb begin
    sout = st;
    if (sin.prime) begin
      sout = '0;
    end else if (restart) begin
      sout.low_total    = sin.total;
      sout.high_total   = sin.total;
      sout.low_agc      = sin.agc;
      sout.high_agc     = sin.agc;
      sout.window_sum   = 23'(sin.total);
      sout.window_count = 14'd1;
    end else begin
      if (sin.agc < st.low_agc) sout.low_agc = sin.agc;
      if (sin.agc > st.high_agc) sout.high_agc = sin.agc;
      if (sin.total < st.low_total) sout.low_total = sin.total;
      if (sin.total > st.high_total) sout.high_total = sin.total;
      sout.window_sum   = st.window_sum + 23'(sin.total);
      sout.window_count = st.window_count + 14'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= sout;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ultrasonic_level_sensor_filter_top.sv
// ----------------------------------------------------------------------------
// ultrasonic_level_sensor_filter_top
// Ultrasonic level sensor filter: counter deltas, voting filter, optional
// second stage, fatal error detection and windowed statistics.
// ----------------------------------------------------------------------------
// Takes one beat per clock and returns one result beat per input beat:
// the beat is held in an input register, processed in one pass of
// combinational logic (deltas, vote, seven-term fluid sum, statistics
// compares), and the result plus the updated state are captured at the
// same edge. The result register keeps its beat while out_stall is high,
// and the input register still takes one more beat meanwhile, so full
// rate is sustained as long as the result side keeps up. A prime beat
// (operation 0) loads the previous counters, reloads the error allowance,
// and clears the other filter state and statistics. Configuration is
// written through cfg_write/cfg_index/cfg_data while no beat is in flight.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_level_sensor_filter_top
  import ulsf_pkg::*;
#(
  parameter int HISTORY_DEPTH = 6,
  parameter int STATS_RESTART = 10000
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  operation,
  input  wire logic [15:0]           raw_counter,
  input  wire logic signed [15:0]    agc_sample,
  input  wire logic                  stats_clear,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       fluid_level,
  output logic                       fatal_error,
  output logic [7:0]                 air_delta,
  output logic [7:0]                 fluid_delta,
  output logic [8:0]                 interval_total,
  output logic [31:0]                accumulated_total,
  output logic [8:0]                 min_total_seen,
  output logic [8:0]                 max_total_seen,
  output logic signed [15:0]         min_agc_seen,
  output logic signed [15:0]         max_agc_seen,
  output logic [22:0]                stats_total_sum,
  output logic [13:0]                stats_sample_count
);

  cfg_t       cfg;
  logic       hold_valid;
  logic       hold_op;
  logic [15:0] hold_raw;
  logic signed [15:0] hold_agc;
  logic       hold_clr;
  logic       fire;

  logic       level_next;
  logic       fatal_next;
  logic [7:0] ad;
  logic [7:0] fd;
  logic [8:0] tot;
  logic [31:0] total_next;
  stats_in_t  sin;
  stats_out_t sout;

  ulsf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Held beat moves on when the result register is free or being emptied
  assign fire     = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_op  <= operation;
      hold_raw <= raw_counter;
      hold_agc <= agc_sample;
      hold_clr <= stats_clear;
    end
  end

  ulsf_level_filter #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_filter (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .fire               (fire),
    .operation          (hold_op),
    .raw_counter        (hold_raw),
    .level_next         (level_next),
    .fatal_next         (fatal_next),
    .air_delta          (ad),
    .fluid_delta        (fd),
    .interval_total     (tot),
    .running_total_next (total_next)
  );

  assign sin.prime = (hold_op == OP_PRIME);
  assign sin.clear = hold_clr;
  assign sin.total = tot;
  assign sin.agc   = hold_agc;

  ulsf_stats #(
    .STATS_RESTART (STATS_RESTART)
  ) u_stats (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .sin  (sin),
    .sout (sout)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      fluid_level        <= level_next;
      fatal_error        <= fatal_next;
      air_delta          <= ad;
      fluid_delta        <= fd;
      interval_total     <= tot;
      accumulated_total  <= total_next;
      min_total_seen     <= sout.low_total;
      max_total_seen     <= sout.high_total;
      min_agc_seen       <= sout.low_agc;
      max_agc_seen       <= sout.high_agc;
      stats_total_sum    <= sout.window_sum;
      stats_sample_count <= sout.window_count;
    end
  end

endmodule

`default_nettype wire
